FILE: hdl/tcst_pkg.sv
// ----------------------------------------------------------------------------
// tcst_pkg: shared types and constants of the three-channel sync timer
// Holds the field widths, request codes, register indexes and controller
// states used by the timer's datapath, controller and top level.
// ----------------------------------------------------------------------------
package tcst_pkg;

    localparam int unsigned ClockDivisor = 8;

    typedef enum logic [1:0]
    {
        REQ_TICK  = 2'd0,
        REQ_HSYNC = 2'd1,
        REQ_VSYNC = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    localparam logic [2:0] REG_CTRL0 = 3'd0;
    localparam logic [2:0] REG_CTRL1 = 3'd1;
    localparam logic [2:0] REG_CTRL2 = 3'd2;
    localparam logic [2:0] REG_TGT0  = 3'd3;
    localparam logic [2:0] REG_TGT1  = 3'd4;
    localparam logic [2:0] REG_TGT2  = 3'd5;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DIRECT,
        ST_DIV0,
        ST_DIV2,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed
    {
        logic load;     // take the item into the datapath
        logic direct;   // apply tick clocks / sync edge
        logic div0;     // one divided step for timer0
        logic div2;     // one divided step for timer2
        logic publish;  // capture the result
    } cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic dot_pending;
        logic div_pending;
    } status_t;

    typedef struct packed
    {
        logic [2:0]  irq_asserted;
        logic [15:0] count_zero;
        logic [15:0] count_one;
        logic [15:0] count_two;
        logic [2:0]  target_hit_flags;
        logic [2:0]  overflow_flags;
    } result_t;

    typedef struct packed
    {
        logic [1:0] req_type;
        logic [6:0] clock_count;
        logic       line_level;
    } item_t;

endpackage

FILE: hdl/tcst_if.sv
// ----------------------------------------------------------------------------
// tcst_in_if / tcst_out_if: valid-ready channels of the sync timer
// Input carries one request item, output one result item.
// ----------------------------------------------------------------------------
interface tcst_in_if;
    logic              valid;
    logic              ready;
    tcst_pkg::item_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface tcst_out_if;
    logic              valid;
    logic              ready;
    tcst_pkg::result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/tcst_datapath.sv
// ----------------------------------------------------------------------------
// tcst_datapath: counters, flags and accumulators of the sync timer
// Executes direct steps and single divided steps on command, loads items,
// publishes results and takes register writes.
module tcst_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcst_pkg::cmd_t    cmd,
    output tcst_pkg::status_t status,
    input  tcst_pkg::item_t   item,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_idx,
    input  logic [15:0]       cfg_data,
    output tcst_pkg::result_t result,
    output logic [8:0]        ctrl_rd [3],
    output logic [15:0]       tgt_rd [3]
);
    import tcst_pkg::*;

    typedef struct packed
    {
        logic [15:0] cnt;
        logic        paused;
        logic        line;
        logic        hit;
        logic        ovf;
        logic        tarm;
        logic        oarm;
    } chan_t;

    logic [8:0]    ctrl_reg [3];
    logic [15:0]   tgt_reg  [3];
    chan_t         ch_reg   [3];
    chan_t         ch_next  [3];
    item_t         item_reg;
    logic [7:0]    dot_reg, dot_next;
    logic [7:0]    div_reg, div_next;
    result_t       res_reg;

    function automatic chan_t fire(chan_t c, logic [8:0] ctl);
        chan_t r;
        r = c;
        if (!ctl[7]) r.line = 1'b0;
        else         r.line = !c.line;
        if (!ctl[6])
        begin
            r.tarm = 1'b0;
            r.oarm = 1'b0;
        end
        return r;
    endfunction

    function automatic chan_t adv(chan_t c, logic [8:0] ctl, logic [15:0] tgt,
                                  logic [6:0] clocks);
        chan_t r;
        logic [16:0] sum;
        r = c;
        sum = {1'b0, c.cnt} + {10'd0, clocks};
        if (!(ctl[0] && c.paused))
        begin
            if (c.cnt < tgt && sum >= {1'b0, tgt})
            begin
                r.hit = 1'b1;
                if (r.tarm) r = fire(r, ctl);
            end
            if (sum[16])
            begin
                r.ovf = 1'b1;
                if (r.oarm) r = fire(r, ctl);
            end
            if (ctl[3] && sum >= {1'b0, tgt}) sum = sum - {1'b0, tgt};
            r.cnt = sum[15:0];
        end
        return r;
    endfunction

    function automatic chan_t syncm(chan_t c, logic [8:0] ctl, logic lvl);
        chan_t r;
        r = c;
        if (ctl[0])
        begin
            unique case (ctl[2:1])
                2'd0: r.paused = 1'b1;
                2'd1: r.cnt = '0;
                2'd2:
                begin
                    r.cnt = '0;
                    r.paused = !lvl;
                end
                default: r.paused = 1'b0;
            endcase
        end
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++) ch_next[i] = ch_reg[i];
        dot_next = dot_reg;
        div_next = div_reg;
        if (cmd.direct)
        begin
            unique case (item_reg.req_type)
                REQ_TICK:
                begin
                    dot_next = dot_reg + {1'b0, item_reg.clock_count};
                    div_next = div_reg + {1'b0, item_reg.clock_count};
                    if (!ctrl_reg[0][8])
                        ch_next[0] = adv(ch_reg[0], ctrl_reg[0], tgt_reg[0],
                                         item_reg.clock_count);
                    if (!ctrl_reg[1][8])
                        ch_next[1] = adv(ch_reg[1], ctrl_reg[1], tgt_reg[1],
                                         item_reg.clock_count);
                    if (!ctrl_reg[2][8] && !ctrl_reg[2][0])
                        ch_next[2] = adv(ch_reg[2], ctrl_reg[2], tgt_reg[2],
                                         item_reg.clock_count);
                end
                REQ_HSYNC:
                begin
                    ch_next[0] = syncm(ch_reg[0], ctrl_reg[0], item_reg.line_level);
                    if (ctrl_reg[1][8])
                        ch_next[1] = adv(ch_reg[1], ctrl_reg[1], tgt_reg[1], 7'd1);
                end
                REQ_VSYNC:
                begin
                    ch_next[1] = syncm(ch_reg[1], ctrl_reg[1], item_reg.line_level);
                    if (ctrl_reg[1][2:1] == 2'd0) ch_next[1].paused = 1'b1;
                end
                default: ;
            endcase
        end
        else if (cmd.div0)
        begin
            dot_next = dot_reg - 8'(ClockDivisor);
            if (ctrl_reg[0][8])
                ch_next[0] = adv(ch_reg[0], ctrl_reg[0], tgt_reg[0], 7'd1);
        end
        else if (cmd.div2)
        begin
            div_next = div_reg - 8'(ClockDivisor);
            if (ctrl_reg[2][8] && !ctrl_reg[2][0])
                ch_next[2] = adv(ch_reg[2], ctrl_reg[2], tgt_reg[2], 7'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ctrl_reg[i] <= '0;
                tgt_reg[i]  <= '0;
                ch_reg[i]   <= '{cnt: '0, paused: 1'b0, line: 1'b1, hit: 1'b0,
                                 ovf: 1'b0, tarm: 1'b0, oarm: 1'b0};
            end
            dot_reg <= '0;
            div_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_idx <= REG_CTRL2)
            begin
                ctrl_reg[cfg_idx[1:0]] <= cfg_data[8:0];
                ch_reg[cfg_idx[1:0]].cnt  <= '0;
                ch_reg[cfg_idx[1:0]].line <= 1'b1;
                ch_reg[cfg_idx[1:0]].tarm <= cfg_data[4];
                ch_reg[cfg_idx[1:0]].oarm <= cfg_data[5];
                ch_reg[cfg_idx[1:0]].paused <= (cfg_data[2:1] == 2'd3) ||
                    (cfg_idx == REG_CTRL2 && cfg_data[2:1] == 2'd0);
            end
            else if (cfg_idx == REG_TGT0) tgt_reg[0] <= cfg_data;
            else if (cfg_idx == REG_TGT1) tgt_reg[1] <= cfg_data;
            else if (cfg_idx == REG_TGT2) tgt_reg[2] <= cfg_data;
        end
        else
        begin
            for (int i = 0; i < 3; i++) ch_reg[i] <= ch_next[i];
            dot_reg <= dot_next;
            div_reg <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) item_reg <= item;
        if (cmd.publish)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_reg.irq_asserted[i]     <= !ch_reg[i].line;
                res_reg.target_hit_flags[i] <= ch_reg[i].hit;
                res_reg.overflow_flags[i]   <= ch_reg[i].ovf;
            end
            res_reg.count_zero <= ch_reg[0].cnt;
            res_reg.count_one  <= ch_reg[1].cnt;
            res_reg.count_two  <= ch_reg[2].cnt;
        end
    end

    assign status.dot_pending = (dot_reg >= 8'(ClockDivisor));
    assign status.div_pending = (div_reg >= 8'(ClockDivisor));
    assign result  = res_reg;
    assign ctrl_rd = ctrl_reg;
    assign tgt_rd  = tgt_reg;

    // accumulators stay below the divisor between items
    a_acc_low: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> dot_reg < 8'(ClockDivisor) && div_reg < 8'(ClockDivisor))
        else $error("accumulator not drained");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.direct, cmd.div0, cmd.div2}) <= 1)
        else $error("conflicting datapath commands");
    a_div_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div0 |-> status.dot_pending)
        else $error("divided step without pending clocks");

endmodule

FILE: hdl/tcst_ctrl.sv
// ----------------------------------------------------------------------------
// tcst_ctrl: sequencer of the sync timer
// Walks one item through the direct step and the divided steps.
// ----------------------------------------------------------------------------
module tcst_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  tcst_pkg::status_t status,
    output tcst_pkg::cmd_t    cmd
);
    import tcst_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        ov_next = ov_reg && !out_ready;
        in_ready = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DIRECT;
                end
            end
            ST_DIRECT:
            begin
                cmd.direct = 1'b1;
                state_next = ST_DIV0;
            end
            ST_DIV0:
            begin
                if (status.dot_pending) cmd.div0 = 1'b1;
                else state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (status.div_pending) cmd.div2 = 1'b1;
                else state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the previous result has gone
                if (!ov_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ready |=> ov_reg)
        else $error("result dropped");
    a_pub: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid)
        else $error("publish without valid");
    a_ld: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_DIRECT)
        else $error("load did not start work");

endmodule

FILE: hdl/three_channel_sync_timer.sv
// ----------------------------------------------------------------------------
// three_channel_sync_timer: three 16-bit counters with hsync/vsync modes
// Each item passes through the direct step, 0 to 32 divided steps and the
// publish step. A new item is taken only when idle, and the result may wait
// for the output; the divided-clock steps are worked one at a time.
// Reset: rst_n clears counters, flags, accumulators, ctrl and tgt registers.
// ----------------------------------------------------------------------------
module three_channel_sync_timer
(
    input  logic        clk,
    input  logic        rst_n,
    tcst_in_if.sink     in_ch,
    tcst_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tcst_pkg::*;

    cmd_t       cmd;
    status_t    status;
    logic       cfg_we;
    logic [2:0] idx;
    logic [8:0]  ctrl_rd [3];
    logic [15:0] tgt_rd  [3];

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        if (idx <= REG_CTRL2)     prdata = {23'd0, ctrl_rd[idx[1:0]]};
        else if (idx == REG_TGT0) prdata = {16'd0, tgt_rd[0]};
        else if (idx == REG_TGT1) prdata = {16'd0, tgt_rd[1]};
        else if (idx == REG_TGT2) prdata = {16'd0, tgt_rd[2]};
    end

    tcst_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .status(status), .cmd(cmd)
    );

    tcst_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .item(in_ch.payload), .cfg_we(cfg_we), .cfg_idx(idx),
        .cfg_data(pwdata[15:0]), .result(out_ch.payload),
        .ctrl_rd(ctrl_rd), .tgt_rd(tgt_rd)
    );

endmodule
